// File: rtl/core/tcgc_pkg.sv
package tcgc_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned INDEX_W  = 2;
  localparam int unsigned DATA_W   = 32;

  // sum of four samples before the divide by four
  localparam int unsigned SUM_W = SAMPLE_W + 2;

  // gesture codes as seen on click_kind
  typedef enum logic [KIND_W-1:0] {
    CLICK_NONE    = 3'd0,
    CLICK_PENDING = 3'd1,
    CLICK_SINGLE  = 3'd2,
    CLICK_DOUBLE  = 3'd3,
    CLICK_LONG    = 3'd4
  } click_code_t;

  // configuration register indexes
  typedef enum logic [INDEX_W-1:0] {
    REG_TOUCH_THRESHOLD = 2'd0,
    REG_GAP_WINDOW      = 2'd1,
    REG_LONG_PRESS      = 2'd2,
    REG_MIN_PRESS       = 2'd3
  } reg_index_t;

  // register values after reset
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET  = 16'd40;
  localparam logic [TIME_W-1:0]   GAP_WINDOW_RESET = 32'd300000;
  localparam logic [TIME_W-1:0]   LONG_PRESS_RESET = 32'd1000000;
  localparam logic [TIME_W-1:0]   MIN_PRESS_RESET  = 32'd50000;

endpackage

// File: rtl/core/touch_click_gesture_classifier.sv
// the output register takes the result of each accepted input transfer
// throughput: one item per cycle while in_stall is low; the gesture state updates in the accept cycle
// and the result register drains independently while out_stall is low
// reset: synchronous, active high; thresholds return to their defaults, the
// gesture state clears, no result is held and configuration is always ready
module touch_click_gesture_classifier (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tcgc_pkg::SAMPLE_W-1:0]       sample_a,
  input  logic [tcgc_pkg::SAMPLE_W-1:0]       sample_b,
  input  logic [tcgc_pkg::SAMPLE_W-1:0]       sample_c,
  input  logic [tcgc_pkg::SAMPLE_W-1:0]       sample_d,
  input  logic [tcgc_pkg::TIME_W-1:0]         now_us,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                gesture_done,
  output logic [tcgc_pkg::KIND_W-1:0]         click_kind,
  output logic [tcgc_pkg::SAMPLE_W-1:0]       touch_level,
  output logic [tcgc_pkg::TIME_W-1:0]         first_press_us,
  output logic [tcgc_pkg::TIME_W-1:0]         second_press_us,
  output logic [tcgc_pkg::TIME_W-1:0]         gap_us,
  output logic                                pressed,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcgc_pkg::INDEX_W-1:0]        cfg_index,
  input  logic [tcgc_pkg::DATA_W-1:0]         cfg_data
);

  import tcgc_pkg::*;

  // configuration registers
  logic [SAMPLE_W-1:0] touch_threshold;
  logic [TIME_W-1:0]   gap_window_us;
  logic [TIME_W-1:0]   long_press_us;
  logic [TIME_W-1:0]   min_press_us;

  // gesture state
  logic                is_pressed,      is_pressed_next;
  click_code_t         click_code,      click_code_next;
  logic [TIME_W-1:0]   press_time,      press_time_next;
  logic [TIME_W-1:0]   release_time,    release_time_next;
  logic [TIME_W-1:0]   wait_time,       wait_time_next;
  logic [SAMPLE_W-1:0] captured_level,  captured_level_next;
  logic [TIME_W-1:0]   first_duration,  first_duration_next;
  logic [TIME_W-1:0]   second_duration, second_duration_next;
  logic [TIME_W-1:0]   double_gap,      double_gap_next;

  // per-item datapath
  logic [SUM_W-1:0]    sample_sum;
  logic [SAMPLE_W-1:0] level;
  logic                touched;
  logic [TIME_W-1:0]   since_release;
  logic [TIME_W-1:0]   press_length;
  logic                confirmed;
  logic                done_next;
  logic                in_accept;

  // config writes land at once; the port never holds off a transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_threshold <= THRESHOLD_RESET;
      gap_window_us   <= GAP_WINDOW_RESET;
      long_press_us   <= LONG_PRESS_RESET;
      min_press_us    <= MIN_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOUCH_THRESHOLD: touch_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_GAP_WINDOW:      gap_window_us   <= cfg_data[TIME_W-1:0];
        REG_LONG_PRESS:      long_press_us   <= cfg_data[TIME_W-1:0];
        REG_MIN_PRESS:       min_press_us    <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // a new item is taken unless a finished result is stuck at the output
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // average of the four readings; below the threshold means touched
  assign sample_sum    = SUM_W'(sample_a) + SUM_W'(sample_b)
                       + SUM_W'(sample_c) + SUM_W'(sample_d);
  assign level         = sample_sum[SUM_W-1:2];
  assign touched       = level < touch_threshold;

  // time differences wrap modulo 2^32
  assign since_release = now_us - release_time;
  assign press_length  = now_us - press_time;

  always_comb begin
    is_pressed_next      = is_pressed;
    click_code_next      = click_code;
    press_time_next      = press_time;
    release_time_next    = release_time;
    wait_time_next       = wait_time;
    captured_level_next  = captured_level;
    first_duration_next  = first_duration;
    second_duration_next = second_duration;
    double_gap_next      = double_gap;
    done_next            = 1'b0;
    confirmed            = 1'b0;

    if (!is_pressed) begin
      // pending single click: confirm once the window has run out
      if (click_code == CLICK_PENDING) begin
        wait_time_next = since_release;
        if (since_release > gap_window_us) begin
          click_code_next = CLICK_SINGLE;
          done_next       = 1'b1;
          confirmed       = 1'b1;
        end
      end
      // the touch of a confirming item is not looked at
      if (!confirmed && touched) begin
        is_pressed_next     = 1'b1;
        press_time_next     = now_us;
        captured_level_next = level;
        wait_time_next      = since_release;
        click_code_next     = (since_release >= gap_window_us) ? CLICK_SINGLE
                                                               : CLICK_DOUBLE;
      end
    end else if (!touched) begin
      // release: classify the press that just ended
      is_pressed_next   = 1'b0;
      release_time_next = now_us;
      if (click_code == CLICK_DOUBLE) begin
        second_duration_next = press_length;
        double_gap_next      = wait_time;
        done_next            = 1'b1;
      end else if (press_length >= long_press_us) begin
        first_duration_next = press_length;
        click_code_next     = CLICK_LONG;
        done_next           = 1'b1;
      end else if (press_length > min_press_us) begin
        first_duration_next = press_length;
        click_code_next     = CLICK_PENDING;
      end
      // a short press leaves the code as set at the press
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_pressed      <= 1'b0;
      click_code      <= CLICK_NONE;
      press_time      <= '0;
      release_time    <= '0;
      wait_time       <= GAP_WINDOW_RESET;
      captured_level  <= '0;
      first_duration  <= '0;
      second_duration <= '0;
      double_gap      <= '0;
    end else if (in_accept) begin
      is_pressed      <= is_pressed_next;
      click_code      <= click_code_next;
      press_time      <= press_time_next;
      release_time    <= release_time_next;
      wait_time       <= wait_time_next;
      captured_level  <= captured_level_next;
      first_duration  <= first_duration_next;
      second_duration <= second_duration_next;
      double_gap      <= double_gap_next;
    end
  end

  // result register: shows the state after the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      gesture_done    <= done_next;
      click_kind      <= click_code_next;
      touch_level     <= captured_level_next;
      first_press_us  <= first_duration_next;
      second_press_us <= second_duration_next;
      gap_us          <= double_gap_next;
      pressed         <= is_pressed_next;
    end
  end

  // a reported gesture is always a finished kind
  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && gesture_done |->
      (click_kind == CLICK_SINGLE) || (click_kind == CLICK_DOUBLE)
      || (click_kind == CLICK_LONG))
    else $error("gesture reported with an unfinished click kind");

  // gestures are only reported while the pad is released
  a_done_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && gesture_done |-> !pressed)
    else $error("gesture reported while pad is pressed");

  // every input transfer yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // the press state held in the result matches the internal state
  a_pressed_tracks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> pressed == is_pressed)
    else $error("result press state differs from internal state");

endmodule
